### rtl/mbps_pkg.sv
// Shared types and constants for the masked byte pattern scanner.
package mbps_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int ADDR_W          = 64;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LOW  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_HIGH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CARE_MASK    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDR    = 3'd4;

    localparam logic [15:0] CARE_MASK_RST   = 16'hFFFF;
    localparam logic [4:0]  PATTERN_LEN_RST = 5'd1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_word;

    typedef struct packed {
        logic              found;
        logic [ADDR_W-1:0] match_address;
    } t_out_word;

    typedef struct packed {
        logic [63:0]       pattern_low_bytes;
        logic [63:0]       pattern_high_bytes;
        logic [15:0]       care_mask;
        logic [4:0]        pattern_length;
        logic [ADDR_W-1:0] region_base;
    } t_cfg;

    // scan result handed from the compare stage to the output stage
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [ADDR_W-1:0] start_offset;
    } t_res;

endpackage

### rtl/masked_byte_pattern_scanner.sv
// Top level of the masked byte pattern scanner.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+-------------------------------
//  in      | input     | i_in_valid / o_in_stall   | t_in_word  (data_byte, final_byte)
//  out     | output    | o_out_valid / i_out_stall | t_out_word (found, match_address)
//  cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One byte is taken every cycle while o_in_stall is low; a result passes through
// the input register, the window compare and the address add in the output register.
// The window compare over all pattern positions is done in parallel.
// Synchronous active-low reset clears all handshake and scan state but the window bytes.
// Stalls on the out channel fill the pipeline before o_in_stall rises.
module masked_byte_pattern_scanner #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  mbps_pkg::t_in_word             i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output mbps_pkg::t_out_word            o_out,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]                    i_cfg_data
);
    import mbps_pkg::*;

    t_cfg w_cfg;
    t_res w_res;
    logic w_out_free;

    mbps_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    mbps_core #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_cfg      (w_cfg),
        .i_out_free (w_out_free),
        .o_res      (w_res)
    );

    mbps_out u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_res         (w_res),
        .i_region_base (w_cfg.region_base),
        .o_out_free    (w_out_free),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out         (o_out)
    );

endmodule

### rtl/mbps_cfg.sv
// Configuration register file of the masked byte pattern scanner.
module mbps_cfg (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mbps_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [63:0]                      i_cfg_data,
    output mbps_pkg::t_cfg                   o_cfg
);
    import mbps_pkg::*;

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_low_bytes  <= '0;
            r_cfg.pattern_high_bytes <= '0;
            r_cfg.care_mask          <= CARE_MASK_RST;
            r_cfg.pattern_length     <= PATTERN_LEN_RST;
            r_cfg.region_base        <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PATTERN_LOW:  r_cfg.pattern_low_bytes  <= i_cfg_data;
                CFG_PATTERN_HIGH: r_cfg.pattern_high_bytes <= i_cfg_data;
                CFG_CARE_MASK:    r_cfg.care_mask          <= i_cfg_data[15:0];
                CFG_PATTERN_LEN:  r_cfg.pattern_length     <= i_cfg_data[4:0];
                CFG_BASE_ADDR:    r_cfg.region_base        <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### rtl/mbps_core.sv
// Input register, byte window, scan state and masked compare with result register.
module mbps_core #(
    parameter int MAX_PATTERN = mbps_pkg::MAX_PATTERN_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  mbps_pkg::t_in_word i_in,
    input  mbps_pkg::t_cfg     i_cfg,
    input  logic               i_out_free,
    output mbps_pkg::t_res     o_res
);
    import mbps_pkg::*;

    localparam int LW   = $clog2(MAX_PATTERN + 1);
    localparam int IW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int NCMP = (MAX_PATTERN < 16) ? MAX_PATTERN : 16;

    // input stage
    logic       r_in_v;
    t_in_word   r_in;

    // scan state
    logic [7:0]        r_win [MAX_PATTERN];
    logic [7:0]        n_win [MAX_PATTERN];
    logic [LW-1:0]     r_fill, n_fill;
    logic [ADDR_W-1:0] r_offset, n_offset;
    logic              r_seen, n_seen;

    // result stage
    logic              r_res_v, n_res_v;
    logic              r_res_found, n_res_found;
    logic [ADDR_W-1:0] r_res_offs, n_res_offs;

    logic          w_res_free, w_in_free, w_take;
    logic [LW-1:0] w_n;
    logic [LW-1:0] w_fill_inc;
    logic [127:0]  w_pat;
    logic          w_eq;
    logic          w_hit;

    assign w_res_free = !r_res_v || i_out_free;
    assign w_in_free  = !r_in_v || w_res_free;
    assign w_take     = r_in_v && w_res_free;
    assign o_in_stall = !w_in_free;

    assign o_res.valid        = r_res_v;
    assign o_res.found        = r_res_found;
    assign o_res.start_offset = r_res_offs;

    assign w_pat = {i_cfg.pattern_high_bytes, i_cfg.pattern_low_bytes};

    // effective pattern length: zero acts as one, clipped to the window depth
    always_comb begin
        if (i_cfg.pattern_length == '0) begin
            w_n = LW'(1);
        end else if (32'(i_cfg.pattern_length) > 32'(MAX_PATTERN)) begin
            w_n = LW'(MAX_PATTERN);
        end else begin
            w_n = LW'(i_cfg.pattern_length);
        end
    end

    assign w_fill_inc = (32'(r_fill) < 32'(MAX_PATTERN)) ? r_fill + LW'(1) : r_fill;

    always_comb begin
        n_win[0] = r_in.data_byte;
        for (int k = 1; k < MAX_PATTERN; k++) begin
            n_win[k] = r_win[k-1];
        end
    end

    // pattern byte j lines up with window entry n-1-j (entry 0 is newest)
    always_comb begin
        w_eq = 1'b1;
        for (int j = 0; j < NCMP; j++) begin
            if (j < 32'(w_n) && i_cfg.care_mask[j]) begin
                if (n_win[IW'(32'(w_n) - 1 - j)] != w_pat[8*j +: 8]) begin
                    w_eq = 1'b0;
                end
            end
        end
    end

    assign w_hit = (w_fill_inc >= w_n) && w_eq;

    always_comb begin
        n_fill      = r_fill;
        n_offset    = r_offset;
        n_seen      = r_seen;
        n_res_v     = r_res_v;
        n_res_found = r_res_found;
        n_res_offs  = r_res_offs;
        if (w_res_free) begin
            n_res_v = 1'b0;
        end
        if (w_take) begin
            n_res_found = w_hit;
            n_res_offs  = r_offset - ADDR_W'(w_n - LW'(1));
            if (!r_seen) begin
                n_fill   = w_fill_inc;
                n_offset = r_offset + ADDR_W'(1);
                n_seen   = w_hit;
                n_res_v  = w_hit || r_in.final_byte;
            end
            if (r_in.final_byte) begin
                n_fill   = '0;
                n_offset = '0;
                n_seen   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v   <= 1'b0;
            r_res_v  <= 1'b0;
            r_fill   <= '0;
            r_offset <= '0;
            r_seen   <= 1'b0;
        end else begin
            if (w_in_free) begin
                r_in_v <= i_in_valid;
            end
            r_res_v  <= n_res_v;
            r_fill   <= n_fill;
            r_offset <= n_offset;
            r_seen   <= n_seen;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_free && i_in_valid) begin
            r_in <= i_in;
        end
        if (w_take && !r_seen) begin
            r_win <= n_win;
        end
        r_res_found <= n_res_found;
        r_res_offs  <= n_res_offs;
    end

endmodule

### rtl/mbps_out.sv
// Output register: adds the base address to the match offset, or gives address zero when not found.
module mbps_out (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mbps_pkg::t_res      i_res,
    input  logic [63:0]         i_region_base,
    output logic                o_out_free,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output mbps_pkg::t_out_word o_out
);
    import mbps_pkg::*;

    logic      r_out_v;
    t_out_word r_out;
    t_out_word n_out;

    assign o_out_free  = !r_out_v || !i_out_stall;
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_comb begin
        n_out.found         = i_res.found;
        n_out.match_address = i_res.found ? i_region_base + i_res.start_offset : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (o_out_free) begin
            r_out_v <= i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_out_free && i_res.valid) begin
            r_out <= n_out;
        end
    end

endmodule

### sim/tb_masked_byte_pattern_scanner.sv
// Self-checking testbench for the masked byte pattern scanner.
`timescale 1ns / 100ps

module tb_masked_byte_pattern_scanner;
    import mbps_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_BYTES = 1200;
    localparam int SETTLE_WAIT  = 10;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in        = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [63:0]          i_cfg_data  = '0;

    masked_byte_pattern_scanner dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // register shadow
    logic [63:0] pat_lo    = '0;
    logic [63:0] pat_hi    = '0;
    logic [15:0] care_bits = CARE_MASK_RST;
    logic [4:0]  pat_len   = PATTERN_LEN_RST;
    logic [63:0] base_addr = '0;

    // scan state
    logic [7:0]  win_bytes [MAX_PATTERN_DEF];
    int          win_fill    = 0;
    logic [63:0] scan_offset = '0;
    logic        scan_done   = 1'b0;

    t_out_word   scan_results_due [$];
    t_out_word   due_word;
    logic [7:0]  region_q [$];

    int idle_pct        = 10;
    int stall_pct       = 10;
    int error_count     = 0;
    int cycle_count     = 0;
    int items_sent      = 0;
    int regions_sent    = 0;
    int results_checked = 0;
    int found_count     = 0;
    int cfg_writes      = 0;

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic int eff_len();
        if (pat_len == 0) return 1;
        if (pat_len > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
        return int'(pat_len);
    endfunction

    function automatic logic [7:0] pattern_byte(input int j);
        if (j < 8) return pat_lo[8*j +: 8];
        return pat_hi[8*(j-8) +: 8];
    endfunction

    function automatic void clear_scan();
        foreach (win_bytes[k]) win_bytes[k] = '0;
        win_fill    = 0;
        scan_offset = '0;
        scan_done   = 1'b0;
    endfunction

    // shifts one byte into the window while no match is seen and queues the result it causes, if any
    function automatic void predict_scan(input t_in_word w);
        int        n;
        logic      hit;
        t_out_word r;
        if (!scan_done) begin
            n = eff_len();
            for (int k = MAX_PATTERN_DEF - 1; k > 0; k--) win_bytes[k] = win_bytes[k-1];
            win_bytes[0] = w.data_byte;
            if (win_fill < MAX_PATTERN_DEF) win_fill++;
            if (win_fill >= n) begin
                hit = 1'b1;
                // pattern byte 0 lines up with the oldest byte of the window
                for (int j = 0; j < n; j++) begin
                    if (care_bits[j] && win_bytes[n-1-j] != pattern_byte(j)) hit = 1'b0;
                end
                if (hit) begin
                    scan_done       = 1'b1;
                    r.found         = 1'b1;
                    r.match_address = base_addr + scan_offset - 64'(n - 1);
                    scan_results_due.insert(scan_results_due.size(), r);
                end
            end
            scan_offset++;
        end
        if (w.final_byte) begin
            if (!scan_done) begin
                r.found         = 1'b0;
                r.match_address = '0;
                scan_results_due.insert(scan_results_due.size(), r);
            end
            clear_scan();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
        error_count++;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        t_in_word w;
        w.data_byte  = b;
        w.final_byte = is_last;
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= w;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        predict_scan(w);
        items_sent++;
        if (is_last) regions_sent++;
    endtask

    // leaves valid high so back-to-back writes need no gap
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        case (idx)
            CFG_PATTERN_LOW:  pat_lo    = data;
            CFG_PATTERN_HIGH: pat_hi    = data;
            CFG_CARE_MASK:    care_bits = data[15:0];
            CFG_PATTERN_LEN:  pat_len   = data[4:0];
            CFG_BASE_ADDR:    base_addr = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // bytes past a match give no result, so wait out the pipe with the output open
    task automatic settle_pipeline();
        int saved_stall;
        i_in_valid <= 1'b0;
        while (scan_results_due.size() != 0) @(posedge i_clk);
        saved_stall = stall_pct;
        stall_pct   = 0;
        repeat (SETTLE_WAIT) @(posedge i_clk);
        stall_pct   = saved_stall;
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, scan_results_due.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            if (scan_results_due.size() == 0) begin
                report_mismatch("unexpected word", {63'd0, o_out.found}, '0);
            end else begin
                due_word = scan_results_due.pop_front();
                if (o_out.found !== due_word.found)
                    report_mismatch("found", {63'd0, o_out.found}, {63'd0, due_word.found});
                if (o_out.match_address !== due_word.match_address)
                    report_mismatch("match_address", o_out.match_address,
                                    due_word.match_address);
                results_checked++;
                if (due_word.found) found_count++;
            end
        end
    end

    // reset registers: zero pattern, length one, all care bits set
    task automatic test_reset_values();
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
    endtask

    // length codes above sixteen clamp; region too short gives not-found
    task automatic test_length_clamp();
        settle_pipeline();
        cfg_write(CFG_PATTERN_LEN, 64'd31);
        cfg_write(CFG_CARE_MASK, 64'd0);
        cfg_write(CFG_BASE_ADDR, '1);
        i_cfg_valid <= 1'b0;
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h80, 1'b1);
        for (int i = 0; i < MAX_PATTERN_DEF; i++)
            send_byte(8'($urandom), i == MAX_PATTERN_DEF - 1);
    endtask

    // length code zero acts as one; start address wraps past all ones
    task automatic test_address_wrap();
        settle_pipeline();
        cfg_write(CFG_PATTERN_LEN, 64'd0);
        cfg_write(CFG_CARE_MASK, 64'hFFFF);
        cfg_write(CFG_PATTERN_LOW, 64'h0123_4567_89AB_CDEF);
        cfg_write(CFG_PATTERN_HIGH, '1);
        i_cfg_valid <= 1'b0;
        send_byte(8'h12, 1'b0);
        send_byte(8'hEF, 1'b1);
    endtask

    // care mask changed with a half-scanned region held in the window
    task automatic test_mid_region_config();
        settle_pipeline();
        cfg_write(CFG_PATTERN_LEN, 64'd2);
        cfg_write(CFG_PATTERN_LOW, 64'h5AA5);
        cfg_write(CFG_CARE_MASK, 64'h0003);
        cfg_write(CFG_BASE_ADDR, 64'h1000);
        i_cfg_valid <= 1'b0;
        send_byte(8'h11, 1'b0);
        send_byte(8'hA5, 1'b0);
        settle_pipeline();
        cfg_write(CFG_CARE_MASK, 64'h0001);
        i_cfg_valid <= 1'b0;
        send_byte(8'h5A, 1'b0);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic randomize_config(input bit write_all);
        int          pick;
        logic [63:0] v;
        if (write_all || $urandom_range(2) == 0) begin
            pick = $urandom_range(9);
            v    = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
            cfg_write(CFG_PATTERN_LOW, v);
        end
        if (write_all || $urandom_range(2) == 0) begin
            pick = $urandom_range(9);
            v    = (pick == 0) ? '0 : (pick == 1) ? '1 : rand64();
            cfg_write(CFG_PATTERN_HIGH, v);
        end
        if (write_all || $urandom_range(1) == 0) begin
            pick = $urandom_range(9);
            if (pick == 0) begin
                v = 64'd0;
            end else if (pick == 1) begin
                v = 64'hFFFF;
            end else begin
                // junk above the mask bits
                v       = rand64();
                v[15:0] = 16'($urandom);
            end
            cfg_write(CFG_CARE_MASK, v);
        end
        if (write_all || $urandom_range(1) == 0) begin
            pick = $urandom_range(9);
            case (pick)
                0:       v = 64'd0;
                1:       v = 64'd16;
                2:       v = 64'($urandom_range(17, 31));
                3: begin
                    v      = rand64();
                    v[4:0] = 5'($urandom_range(1, 16));
                end
                default: v = 64'($urandom_range(1, 16));
            endcase
            cfg_write(CFG_PATTERN_LEN, v);
        end
        if (write_all || $urandom_range(2) == 0) begin
            pick = $urandom_range(9);
            v    = (pick == 0) ? '0 : (pick == 1) ? ~64'($urandom_range(20)) : rand64();
            cfg_write(CFG_BASE_ADDR, v);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // one region: mostly a planted pattern inside random bytes, else noise,
    // a planted pattern with one care byte flipped, or a region too short
    task automatic send_region();
        int n;
        int kind;
        int pos;
        int start;
        int j;
        int split;
        bit flipped;
        n       = eff_len();
        kind    = $urandom_range(9);
        split   = -1;
        flipped = 1'b0;
        region_q.delete();
        if (kind == 9 && n > 1) begin
            repeat ($urandom_range(1, n - 1)) region_q.insert(region_q.size(), 8'($urandom));
        end else if (kind == 7) begin
            repeat ($urandom_range(1, 24)) region_q.insert(region_q.size(), 8'($urandom));
        end else begin
            repeat ($urandom_range(0, 12)) region_q.insert(region_q.size(), 8'($urandom));
            pos = region_q.size();
            for (int k = 0; k < n; k++)
                region_q.insert(region_q.size(),
                                care_bits[k] ? pattern_byte(k) : 8'($urandom));
            if (kind == 8) begin
                start = $urandom_range(0, n - 1);
                for (int k = 0; k < n; k++) begin
                    j = (start + k) % n;
                    if (care_bits[j] && !flipped) begin
                        region_q[pos + j] = ~region_q[pos + j];
                        flipped = 1'b1;
                    end
                end
            end
            repeat ($urandom_range(0, 6)) region_q.insert(region_q.size(), 8'($urandom));
            if ($urandom_range(9) == 0) split = $urandom_range(0, region_q.size() - 1);
        end
        foreach (region_q[i]) begin
            if (i == split) begin
                settle_pipeline();
                case ($urandom_range(2))
                    0:       cfg_write(CFG_BASE_ADDR, rand64());
                    1:       cfg_write(CFG_CARE_MASK, 64'($urandom));
                    default: cfg_write(CFG_PATTERN_LEN, 64'($urandom_range(1, 16)));
                endcase
                i_cfg_valid <= 1'b0;
            end
            send_byte(region_q[i], i == region_q.size() - 1);
        end
    endtask

    task automatic test_random_regions();
        int target;
        int phase;
        bit quiet;
        target = items_sent + RANDOM_BYTES;
        phase  = 0;
        while (items_sent < target) begin
            settle_pipeline();
            // every eighth phase runs with no gaps and no stalls
            quiet     = (phase % 8 == 3);
            idle_pct  = quiet ? 0 : 10;
            stall_pct = quiet ? 0 : 10;
            randomize_config(phase == 0);
            repeat (quiet ? 10 : $urandom_range(2, 6)) send_region();
            phase++;
        end
    endtask

    initial begin
        clear_scan();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_values();
        test_length_clamp();
        test_address_wrap();
        test_mid_region_config();
        test_random_regions();
        settle_pipeline();
        $display("scanned %0d bytes in %0d regions with %0d register writes",
                 items_sent, regions_sent, cfg_writes);
        $display("checked %0d results, %0d of them matches, %0d mismatches",
                 results_checked, found_count, error_count);
        if (error_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
